// ----- design/gda_pkg.sv -----
// Package for the Gregorian date adder.
// Holds field widths, the sequencer/year-counter control struct and the
// calendar length helpers. No dependencies.
package gda_pkg;

    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int OFFSET_W = 20;
    // Internal year count runs one bit wider: converting back can pass 16383.
    localparam int YCNT_W   = YEAR_W + 1;
    // Ordinal day number: 16383 years plus the largest offset fits in 24 bits.
    localparam int ACC_W    = 24;
    localparam int LEN_W    = 9;

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 24;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic clear;   // restart at year 1
        logic step;    // advance one year
    } yr_ctl_t;

    function automatic logic [LEN_W-1:0] year_len(input logic leap);
        logic [LEN_W-1:0] len;
        len = leap ? LEN_W'(366) : LEN_W'(365);
        return len;
    endfunction

    function automatic logic [LEN_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
        logic [LEN_W-1:0] len;
        case (month)
            4'd2:                     len = leap ? LEN_W'(29) : LEN_W'(28);
            4'd4, 4'd6, 4'd9, 4'd11:  len = LEN_W'(30);
            default:                  len = LEN_W'(31);
        endcase
        return len;
    endfunction

endpackage

// ----- design/gda_year_ctr.sv -----
// Year counter with running remainders mod 4/100/400 and leap flag.
// Depends on gda_pkg.
module gda_year_ctr
    import gda_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  yr_ctl_t           ctl,
    output logic [YCNT_W-1:0] year,
    output logic              leap
);

    logic [YCNT_W-1:0] year_reg, year_next;
    logic [6:0]        c100_reg, c100_next;
    logic [8:0]        c400_reg, c400_next;

    always_comb begin
        year_next = year_reg;
        c100_next = c100_reg;
        c400_next = c400_reg;
        if (ctl.clear) begin
            year_next = YCNT_W'(1);
            c100_next = 7'd1;
            c400_next = 9'd1;
        end else if (ctl.step) begin
            year_next = year_reg + YCNT_W'(1);
            c100_next = (c100_reg == 7'd99)  ? 7'd0 : c100_reg + 7'd1;
            c400_next = (c400_reg == 9'd399) ? 9'd0 : c400_reg + 9'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            year_reg <= YCNT_W'(1);
            c100_reg <= 7'd1;
            c400_reg <= 9'd1;
        end else begin
            year_reg <= year_next;
            c100_reg <= c100_next;
            c400_reg <= c400_next;
        end
    end

    // 2^15 wrap is a multiple of 4, so the low bits stay the year mod 4
    assign year = year_reg;
    assign leap = (c400_reg == 9'd0) || ((year_reg[1:0] == 2'd0) && (c100_reg != 7'd0));

endmodule

// ----- design/gda_alu.sv -----
// Shared add/subtract unit with greater-than flag for subtraction.
// Depends on gda_pkg.
module gda_alu
    import gda_pkg::*;
(
    input  logic [ACC_W-1:0] acc,
    input  logic [ACC_W-1:0] opnd,
    input  logic             sub,
    output logic [ACC_W-1:0] res,
    output logic             gt     // acc > opnd, valid when sub
);

    logic [ACC_W:0] sum;

    always_comb begin
        sum = {1'b0, acc} + {1'b0, (sub ? ~opnd : opnd)} + {{ACC_W{1'b0}}, sub};
    end

    assign res = sum[ACC_W-1:0];
    // carry out means no borrow; nonzero difference means strictly greater
    assign gt  = sum[ACC_W] && (sum[ACC_W-1:0] != '0);

endmodule

// ----- design/gregorian_date_add_days.sv -----
// Gregorian date adder, top level.
// Depends on gda_pkg, gda_year_ctr and gda_alu.
//
// Usage:
//   Input channel s_*: one transaction carries a start date and a day count.
//   Output channel m_*: one transaction per input carries the resulting date.
//   Dates are proleptic Gregorian, years counted from year 1.
//
// Operation: the start date becomes an ordinal day number by walking year by
// year from year 1 and month by month, adding lengths through one shared
// adder; the offset and day are added; then whole years and months are
// subtracted through the same adder until the remainder is the day of month.
//
// The walk takes one year or month per cycle; year 0 walks like year 1, and
// months are walked after clamping.
// Throughput: one item at a time; s_tready is high only while idle.
// The result sits in an output register, so a new item is taken while the
// previous result still waits; a stalled receiver only holds the finishing
// step when a second result is ready.
// Reset (aresetn low, synchronous) returns to idle with no result pending.
module gregorian_date_add_days
    import gda_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // {start_day[4:0], start_month[8:5], start_year[22:9], offset_days[42:23],
    //  zero pad[47:43]} from bit 0 up
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // {result_day[4:0], result_month[8:5], result_year[22:9], zero pad[23]} from bit 0 up
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam logic [2:0] ST_IDLE       = 3'd0;
    localparam logic [2:0] ST_YEARS_IN   = 3'd1;
    localparam logic [2:0] ST_MONTHS_IN  = 3'd2;
    localparam logic [2:0] ST_ADD_OFF    = 3'd3;
    localparam logic [2:0] ST_ADD_DAY    = 3'd4;
    localparam logic [2:0] ST_YEARS_OUT  = 3'd5;
    localparam logic [2:0] ST_MONTHS_OUT = 3'd6;
    localparam logic [2:0] ST_FINISH     = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [DAY_W-1:0]    day_reg, day_next;
    logic [MONTH_W-1:0]  month_reg, month_next;
    logic [YEAR_W-1:0]   year_reg, year_next;
    logic [OFFSET_W-1:0] off_reg, off_next;
    logic [MONTH_W-1:0]  mon_reg, mon_next;      // month walker
    logic [ACC_W-1:0]    acc_reg, acc_next;      // ordinal day accumulator
    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    yr_ctl_t             yctl;
    logic [YCNT_W-1:0]   cur_year;
    logic                cur_leap;
    logic                start_leap;

    logic [ACC_W-1:0]    alu_opnd;
    logic                alu_sub;
    logic [ACC_W-1:0]    alu_res;
    logic                alu_gt;

    logic                in_fire;
    logic [MONTH_W-1:0]  in_month;

    gda_year_ctr u_year_ctr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (yctl),
        .year    (cur_year),
        .leap    (cur_leap)
    );

    gda_alu u_alu (
        .acc  (acc_reg),
        .opnd (alu_opnd),
        .sub  (alu_sub),
        .res  (alu_res),
        .gt   (alu_gt)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;

    // month 0 counts as January, 13..15 as December
    always_comb begin
        in_month = s_tdata[8:5];
        if (in_month == 4'd0) begin
            in_month = MONTH_JAN;
        end else if (in_month > MONTH_DEC) begin
            in_month = MONTH_DEC;
        end
    end

    // year 0 has no preceding years and counts as leap
    assign start_leap = (year_reg == '0) || cur_leap;

    // operand select for the shared adder
    always_comb begin
        alu_opnd = '0;
        alu_sub  = 1'b0;
        unique case (state_reg)
            ST_YEARS_IN:   alu_opnd = ACC_W'(year_len(cur_leap));
            ST_MONTHS_IN:  alu_opnd = ACC_W'(month_len(mon_reg, start_leap));
            ST_ADD_OFF:    alu_opnd = ACC_W'(off_reg);
            ST_ADD_DAY:    alu_opnd = ACC_W'(day_reg);
            ST_YEARS_OUT: begin
                alu_opnd = ACC_W'(year_len(cur_leap));
                alu_sub  = 1'b1;
            end
            ST_MONTHS_OUT: begin
                alu_opnd = ACC_W'(month_len(mon_reg, cur_leap));
                alu_sub  = 1'b1;
            end
            default: begin
                alu_opnd = '0;
                alu_sub  = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        day_next     = day_reg;
        month_next   = month_reg;
        year_next    = year_reg;
        off_next     = off_reg;
        mon_next     = mon_reg;
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        yctl         = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    day_next   = s_tdata[4:0];
                    month_next = in_month;
                    year_next  = s_tdata[22:9];
                    off_next   = s_tdata[42:23];
                    mon_next   = MONTH_JAN;
                    acc_next   = '0;
                    yctl.clear = 1'b1;
                    state_next = ST_YEARS_IN;
                end
            end
            ST_YEARS_IN: begin
                // add lengths of years 1 .. start_year-1
                if ({1'b0, year_reg} > cur_year) begin
                    acc_next  = alu_res;
                    yctl.step = 1'b1;
                end else begin
                    state_next = ST_MONTHS_IN;
                end
            end
            ST_MONTHS_IN: begin
                if (mon_reg < month_reg) begin
                    acc_next = alu_res;
                    mon_next = mon_reg + MONTH_W'(1);
                end else begin
                    state_next = ST_ADD_OFF;
                end
            end
            ST_ADD_OFF: begin
                acc_next   = alu_res;
                state_next = ST_ADD_DAY;
            end
            ST_ADD_DAY: begin
                acc_next   = alu_res;
                mon_next   = MONTH_JAN;
                yctl.clear = 1'b1;
                state_next = ST_YEARS_OUT;
            end
            ST_YEARS_OUT: begin
                // remove whole years while more than a full year remains
                if (alu_gt) begin
                    acc_next  = alu_res;
                    yctl.step = 1'b1;
                end else begin
                    state_next = ST_MONTHS_OUT;
                end
            end
            ST_MONTHS_OUT: begin
                if ((acc_reg != '0) && (mon_reg < MONTH_DEC) && alu_gt) begin
                    acc_next = alu_res;
                    mon_next = mon_reg + MONTH_W'(1);
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, cur_year[YEAR_W-1:0], mon_reg, acc_reg[DAY_W-1:0]};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        day_reg    <= day_next;
        month_reg  <= month_next;
        year_reg   <= year_next;
        off_reg    <= off_next;
        mon_reg    <= mon_next;
        acc_reg    <= acc_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
